FILE: design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tdq_pkg.sv
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types and constants of the timed release delay queue
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TIME_WIDTH_DEF  = 48;

    localparam int HANDLE_W  = 16;
    localparam int DELAY_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 7;
    localparam int US_PER_MS = 1000;
    localparam int MS_CONST_W = 10;
    localparam int PROD_W    = DELAY_W + MS_CONST_W;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_POLL    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic calc;
        logic exec;
    } cmd_t;

endpackage

FILE: design/tdq_ctrl.sv
// ----------------------------------------------------------------------------
// tdq_ctrl
// request sequencer: load, compute release time, update the sorted store
// ----------------------------------------------------------------------------
module tdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output tdq_pkg::cmd_t cmd
);
    import tdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == S_CALC);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = S_IDLE;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_CALC : S_IDLE;
            S_CALC:  state_next = S_EXEC;
            S_EXEC:  state_next = accept ? S_CALC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load = accept;
    assign cmd.calc = (state_reg == S_CALC);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

FILE: design/tdq_dp.sv
// ----------------------------------------------------------------------------
// tdq_dp
// release time arithmetic, shift-insert sorted cell row and result registers
// ----------------------------------------------------------------------------
module tdq_dp #(
    parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = tdq_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdq_pkg::cmd_t                 cmd,
    input  logic                          operation,
    input  logic [tdq_pkg::HANDLE_W-1:0]  packet_handle,
    input  logic [TIME_WIDTH-1:0]         arrival_time,
    input  logic [tdq_pkg::DELAY_W-1:0]   delay_ms,
    input  logic [TIME_WIDTH-1:0]         current_time,
    output logic                          done,
    output logic [tdq_pkg::STATUS_W-1:0]  status,
    output logic [tdq_pkg::HANDLE_W-1:0]  released_handle,
    output logic [tdq_pkg::OCC_W-1:0]     occupancy
);
    import tdq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = TIME_WIDTH + 1;

    // request registers
    logic                  op_reg;
    logic [HANDLE_W-1:0]   hdl_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [TIME_WIDTH-1:0] key_reg;

    // sorted cells, head at index 0
    logic [TIME_WIDTH-1:0] rel_q  [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]   hdl_q  [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] up_rel [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]   up_hdl [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] dn_rel [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]   dn_hdl [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] after_key;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic                  done_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [HANDLE_W-1:0]   rhdl_reg;
    logic [HANDLE_W-1:0]   rhdl_next;
    logic [OCC_W-1:0]      occ_reg;

    logic [SUM_W-1:0]      sum;
    logic [TIME_WIDTH-1:0] sat_rel;
    logic                  full;
    logic                  head_due;
    logic                  ins_en;
    logic                  rem_en;

    // saturating release time
    assign sum     = {1'b0, time_reg} + SUM_W'(prod_reg);
    assign sat_rel = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            hdl_reg  <= packet_handle;
            time_reg <= (operation == OP_POLL) ? current_time : arrival_time;
            prod_reg <= PROD_W'(delay_ms) * PROD_W'(US_PER_MS);
        end
        if (cmd.calc)
        begin
            key_reg <= (op_reg == OP_POLL) ? time_reg : sat_rel;
        end
    end

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due = (count_reg != '0) && (rel_q[0] <= key_reg);
    assign ins_en   = cmd.exec && (op_reg == OP_ENQUEUE) && !full;
    assign rem_en   = cmd.exec && (op_reg == OP_POLL) && head_due;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            // empty cells and later releases sit after the new key
            assign after_key[i] = !(CNT_W'(i) < count_reg) || (rel_q[i] > key_reg);

            if (i == 0)
            begin : g_up_head
                assign up_rel[i] = key_reg;
                assign up_hdl[i] = hdl_reg;
            end
            else
            begin : g_up_body
                assign up_rel[i] = after_key[i-1] ? rel_q[i-1] : key_reg;
                assign up_hdl[i] = after_key[i-1] ? hdl_q[i-1] : hdl_reg;
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_dn_tail
                assign dn_rel[i] = rel_q[i];
                assign dn_hdl[i] = hdl_q[i];
            end
            else
            begin : g_dn_body
                assign dn_rel[i] = rel_q[i+1];
                assign dn_hdl[i] = hdl_q[i+1];
            end

            always_ff @(posedge clk)
            begin
                if (ins_en && after_key[i])
                begin
                    rel_q[i] <= up_rel[i];
                    hdl_q[i] <= up_hdl[i];
                end
                else if (rem_en)
                begin
                    rel_q[i] <= dn_rel[i];
                    hdl_q[i] <= dn_hdl[i];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        rhdl_next   = '0;
        status_next = ST_NOTHING;
        if (op_reg == OP_ENQUEUE)
        begin
            if (full)
            begin
                status_next = ST_DROPPED;
            end
            else
            begin
                status_next = ST_ENQUEUED;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else if (head_due)
        begin
            status_next = ST_RELEASED;
            rhdl_next   = hdl_q[0];
            count_next  = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_ENQUEUED;
            rhdl_reg   <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
                rhdl_reg   <= rhdl_next;
                occ_reg    <= OCC_W'(count_next);
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign released_handle = rhdl_reg;
    assign occupancy       = occ_reg;

endmodule

FILE: design/timed_release_delay_queue_core.sv
// ----------------------------------------------------------------------------
// timed_release_delay_queue_core
// packet delay queue ordered by release time, with poll-driven release
// ----------------------------------------------------------------------------
// a new request is refused (busy high) during the release time add stage and is
//   taken during the compare-and-shift update of the sorted cell row
// reset: rst_n clears the entry count, sequencer and result strobe; the cells
//   hold no reset value and are read only below the entry count
// the receiver cannot stall: done is high for exactly one cycle per request
// ----------------------------------------------------------------------------
module timed_release_delay_queue_core #(
    parameter int QUEUE_DEPTH = tdq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = tdq_pkg::TIME_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [tdq_pkg::HANDLE_W-1:0]  packet_handle,
    input  logic [TIME_WIDTH-1:0]         arrival_time,
    input  logic [tdq_pkg::DELAY_W-1:0]   delay_ms,
    input  logic [TIME_WIDTH-1:0]         current_time,
    // result side
    output logic                          done,
    output logic [tdq_pkg::STATUS_W-1:0]  status,
    output logic [tdq_pkg::HANDLE_W-1:0]  released_handle,
    output logic [tdq_pkg::OCC_W-1:0]     occupancy
);
    import tdq_pkg::*;

    cmd_t cmd;

    // sequencer: idle, release time add, store update; a new request is
    // taken in the update cycle so successive requests overlap
    tdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath: the load cycle registers delay_ms times 1000, the add stage
    // saturates arrival plus delay to the largest time value, and the update
    // cycle inserts after every entry with an equal or earlier release (drops if full),
    // or pops the head when its release time is at or before current_time
    tdq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .packet_handle   (packet_handle),
        .arrival_time    (arrival_time),
        .delay_ms        (delay_ms),
        .current_time    (current_time),
        .done            (done),
        .status          (status),
        .released_handle (released_handle),
        .occupancy       (occupancy)
    );

endmodule

FILE: design/tdq_checker.sv
// ----------------------------------------------------------------------------
// tdq_checker
// port-level checks of request timing and result fields
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [tdq_pkg::STATUS_W-1:0]  status,
    input logic [tdq_pkg::HANDLE_W-1:0]  released_handle,
    input logic [tdq_pkg::OCC_W-1:0]     occupancy
);
    import tdq_pkg::*;

    // an accepted request makes the block busy for one cycle
    `CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `CHK_NEXT(a_busy_short, busy, !busy, "busy held longer than one cycle")

    // every result follows a busy cycle of its request
    `CHK_SAME(a_done_origin, done, $past(busy, 2), "result without a request")

    // handle only reported on a release
    `CHK_SAME(a_handle_zero, done && (status != ST_RELEASED), released_handle == '0,
        "handle reported without a release")

    // an enqueue leaves at least one entry
    `CHK_SAME(a_occ_enq, done && (status == ST_ENQUEUED), occupancy != '0,
        "enqueue reported an empty queue")

endmodule

bind timed_release_delay_queue_core tdq_checker u_tdq_checker (.*);
